// ===== sv/srpc_pkg.sv =====
// Shared definitions for the servo response packet checker.
// Holds operation, status and register codes plus the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps

package srpc_pkg;

   // Request operation codes.
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Result status codes.
   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_TIMEOUT      = 2'd1;
   localparam logic [1:0] ST_BAD_HEADER   = 2'd2;
   localparam logic [1:0] ST_BAD_CHECKSUM = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_PACKET_LENGTH = 2'd0;
   localparam logic [1:0] CSR_BYTE_ORDER    = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_LIMIT = 2'd2;

   localparam logic [7:0]  HEADER_MARK       = 8'hFF;
   localparam logic [4:0]  MIN_PACKET        = 5'd6;
   localparam logic [15:0] TICK_MAX          = 16'hFFFF;
   localparam logic [4:0]  RST_PACKET_LENGTH = 5'd8;
   localparam logic        RST_BYTE_ORDER    = 1'b0;
   localparam logic [15:0] RST_TIMEOUT_LIMIT = 16'd10;

   typedef struct packed {
      logic [4:0]  packet_length;
      logic        byte_order;
      logic [15:0] timeout_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] data_value;
      logic [7:0]  error_byte;
      logic [7:0]  node_id;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type result;
   } push_type;

endpackage

// ===== sv/srpc_parse.sv =====
// Packet parser stage: input register, packet state and result formation.
// Depends on srpc_pkg.
`timescale 1ns / 1ps

module srpc_parse #(
   parameter int MAX_PACKET_BYTES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  srpc_pkg::cfg_type  cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [1:0]         in_op,
   input  logic [7:0]         in_byte,
   input  logic               out_space,
   output srpc_pkg::push_type push
);

   localparam logic [4:0] MAX_LEN = 5'(MAX_PACKET_BYTES);

   // Input register.
   logic       hold_valid_ff, hold_valid_in;
   logic [1:0] hold_op_ff;
   logic [7:0] hold_byte_ff;

   // Packet state.
   logic        armed_ff, armed_in;
   logic [4:0]  bytes_seen_ff, bytes_seen_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic        header_good_ff, header_good_in;
   logic [7:0]  held_id_ff, held_id_in;
   logic [7:0]  held_error_ff, held_error_in;
   logic [7:0]  value_first_ff, value_first_in;
   logic [7:0]  value_second_ff, value_second_in;
   logic [15:0] elapsed_ticks_ff, elapsed_ticks_in;

   logic [4:0]  eff_len;
   logic [4:0]  last_pos;
   logic [15:0] ticks_next;
   logic        produce;
   logic        advance;
   srpc_pkg::result_type result;

   always_comb begin
      if (cfg.packet_length < srpc_pkg::MIN_PACKET) begin
         eff_len = srpc_pkg::MIN_PACKET;
      end else if (cfg.packet_length > MAX_LEN) begin
         eff_len = MAX_LEN;
      end else begin
         eff_len = cfg.packet_length;
      end
   end

   assign last_pos   = eff_len - 5'd1;
   assign ticks_next = (elapsed_ticks_ff == srpc_pkg::TICK_MAX) ? elapsed_ticks_ff
                                                               : elapsed_ticks_ff + 16'd1;

   always_comb begin
      produce = 1'b0;
      result  = '0;
      if (hold_valid_ff && armed_ff) begin
         case (hold_op_ff)
            srpc_pkg::OP_BYTE: begin
               if (bytes_seen_ff >= last_pos) begin
                  produce = 1'b1;
                  if (!header_good_ff) begin
                     result.status = srpc_pkg::ST_BAD_HEADER;
                  end else if (~running_sum_ff != hold_byte_ff) begin
                     result.status = srpc_pkg::ST_BAD_CHECKSUM;
                  end else begin
                     result.status = srpc_pkg::ST_OK;
                  end
                  result.node_id    = held_id_ff;
                  result.error_byte = held_error_ff;
                  result.data_value = cfg.byte_order ? {value_first_ff, value_second_ff}
                                                     : {value_second_ff, value_first_ff};
               end
            end
            srpc_pkg::OP_TICK: begin
               if (ticks_next >= cfg.timeout_limit) begin
                  produce       = 1'b1;
                  result.status = srpc_pkg::ST_TIMEOUT;
               end
            end
            default: begin
               produce = 1'b0;
            end
         endcase
      end
   end

   assign advance       = !produce || out_space;
   assign in_ready      = !hold_valid_ff || advance;
   assign hold_valid_in = in_valid || (hold_valid_ff && !advance);
   assign push.valid    = produce && advance;
   assign push.result   = result;

   always_comb begin
      armed_in         = armed_ff;
      bytes_seen_in    = bytes_seen_ff;
      running_sum_in   = running_sum_ff;
      header_good_in   = header_good_ff;
      held_id_in       = held_id_ff;
      held_error_in    = held_error_ff;
      value_first_in   = value_first_ff;
      value_second_in  = value_second_ff;
      elapsed_ticks_in = elapsed_ticks_ff;
      if (hold_valid_ff && advance) begin
         if (hold_op_ff == srpc_pkg::OP_START) begin
            armed_in         = 1'b1;
            bytes_seen_in    = '0;
            running_sum_in   = '0;
            header_good_in   = 1'b1;
            held_id_in       = '0;
            held_error_in    = '0;
            value_first_in   = '0;
            value_second_in  = '0;
            elapsed_ticks_in = '0;
         end else if (armed_ff && hold_op_ff == srpc_pkg::OP_BYTE) begin
            bytes_seen_in = bytes_seen_ff + 5'd1;
            if (bytes_seen_ff >= last_pos) begin
               armed_in = 1'b0;
            end else if (bytes_seen_ff < 5'd2) begin
               if (hold_byte_ff != srpc_pkg::HEADER_MARK) begin
                  header_good_in = 1'b0;
               end
            end else begin
               running_sum_in = running_sum_ff + hold_byte_ff;
               case (bytes_seen_ff)
                  5'd2:    held_id_in      = hold_byte_ff;
                  5'd4:    held_error_in   = hold_byte_ff;
                  5'd5:    value_first_in  = hold_byte_ff;
                  5'd6:    value_second_in = hold_byte_ff;
                  default: running_sum_in  = running_sum_ff + hold_byte_ff;
               endcase
            end
         end else if (armed_ff && hold_op_ff == srpc_pkg::OP_TICK) begin
            elapsed_ticks_in = ticks_next;
            if (produce) begin
               armed_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff    <= 1'b0;
         armed_ff         <= 1'b0;
         bytes_seen_ff    <= '0;
         running_sum_ff   <= '0;
         header_good_ff   <= 1'b1;
         held_id_ff       <= '0;
         held_error_ff    <= '0;
         value_first_ff   <= '0;
         value_second_ff  <= '0;
         elapsed_ticks_ff <= '0;
      end else begin
         hold_valid_ff    <= hold_valid_in;
         armed_ff         <= armed_in;
         bytes_seen_ff    <= bytes_seen_in;
         running_sum_ff   <= running_sum_in;
         header_good_ff   <= header_good_in;
         held_id_ff       <= held_id_in;
         held_error_ff    <= held_error_in;
         value_first_ff   <= value_first_in;
         value_second_ff  <= value_second_in;
         elapsed_ticks_ff <= elapsed_ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         hold_op_ff   <= in_op;
         hold_byte_ff <= in_byte;
      end
   end

endmodule

// ===== sv/srpc_obuf.sv =====
// Two-entry result buffer between the parser and the response channel.
// Depends on srpc_pkg.
`timescale 1ns / 1ps

module srpc_obuf (
   input  logic                 clock,
   input  logic                 reset,
   input  srpc_pkg::push_type   push,
   output logic                 space,
   output logic                 out_valid,
   input  logic                 out_ready,
   output srpc_pkg::result_type out_result
);

   srpc_pkg::result_type entry_ff [2];
   logic [1:0] count_ff, count_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       pop;

   assign out_valid  = (count_ff != 2'd0);
   assign out_result = entry_ff[rd_ptr_ff];
   assign pop        = out_valid && out_ready;
   assign space      = (count_ff != 2'd2) || out_ready;

   always_comb begin
      count_in  = count_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (push.valid) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.result;
      end
   end

endmodule

// ===== sv/servo_response_packet_checker_unit.sv =====
// Top level of the servo response packet checker: configuration registers,
// parser stage and result buffer. Depends on srpc_pkg, srpc_parse and srpc_obuf.
// The result of a request that closes a packet is registered in the parser's input
// register and then in the result buffer, from which it is valid on the response channel.
// Throughput: one request per cycle while the result buffer has room; requests that close no packet send no response.
// Reset (synchronous, active high) empties both stages, disarms, length 8, LE, 10 ticks.
`timescale 1ns / 1ps

module servo_response_packet_checker_unit #(
   parameter int MAX_PACKET_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] operation
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] node id, [15:8] error_byte, [31:16] data_value
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // Configuration write port.
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // Configuration registers. Writes must come only while no request is in flight;
   // the block does not enforce this, and the parser reads them directly without any shadowing.
   srpc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            srpc_pkg::CSR_PACKET_LENGTH: cfg_in.packet_length = csr_wdata[4:0];
            srpc_pkg::CSR_BYTE_ORDER:    cfg_in.byte_order    = csr_wdata[0];
            srpc_pkg::CSR_TIMEOUT_LIMIT: cfg_in.timeout_limit = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.packet_length <= srpc_pkg::RST_PACKET_LENGTH;
         cfg_ff.byte_order    <= srpc_pkg::RST_BYTE_ORDER;
         cfg_ff.timeout_limit <= srpc_pkg::RST_TIMEOUT_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The parser holds one request in its input register and updates the packet
   // state when that request moves on. A request that closes a packet moves on
   // only when the result buffer has room for its result.
   srpc_pkg::push_type   push;
   srpc_pkg::result_type out_result;
   logic                 space;

   srpc_parse #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (req_tuser),
      .in_byte   (req_tdata),
      .out_space (space),
      .push      (push)
   );

   // The two-entry buffer lets the parser keep accepting requests while a
   // finished result waits on the response side.
   srpc_obuf u_obuf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .space      (space),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (out_result)
   );

   assign rsp_tdata = {out_result.data_value, out_result.error_byte, out_result.node_id};
   assign rsp_tuser = out_result.status;

endmodule

// ===== sv/srpc_checker.sv =====
// Port-level checks for the servo response packet checker, bound to the top level.
// Depends on srpc_pkg and servo_response_packet_checker_unit.
`timescale 1ns / 1ps

module srpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // Reset leaves both stages empty.
   assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("stages not empty after reset");

   // Backpressure only reaches the request side once results are waiting.
   assert property (@(posedge clock) disable iff (reset) !req_tready |-> rsp_tvalid)
      else $error("request side stalled with no result pending");

   // A timeout carries no packet contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == srpc_pkg::ST_TIMEOUT |-> rsp_tdata == 32'd0)
      else $error("timeout result with nonzero fields");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind servo_response_packet_checker_unit srpc_checker u_srpc_checker (.*);

// ===== sim/tb_top.sv =====
// Self-checking testbench for servo_response_packet_checker_unit.
// Drives status packets, ticks and stray requests, predicts every response and checks
// it field by field. Depends on srpc_pkg and the checker RTL only.
`timescale 1ns / 1ps

module tb_top;

   localparam int PKT_MAX       = 16;
   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 6;
   // A closing request's result passes the input register and result buffer; allow some slack.
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_ITEMS  = 1400;
   localparam int WATCHDOG_NS   = 4000000;
   localparam int MAX_PRINTED   = 40;

   // Codes that the package leaves unnamed.
   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam logic [1:0] CSR_UNUSED  = 2'd3;

   // Byte offsets inside a status packet.
   localparam int HEADER_BYTES = 2;
   localparam int OFS_ID       = 2;
   localparam int OFS_ERROR    = 4;
   localparam int OFS_VALUE_A  = 5;
   localparam int OFS_VALUE_B  = 6;

   // Header corruption choices for the frame builder.
   localparam int HDR_NONE   = 0;
   localparam int HDR_FIRST  = 1;
   localparam int HDR_SECOND = 2;
   localparam int HDR_BOTH   = 3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] rx_byte
   logic [1:0]  req_tuser = '0;   // [1:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [7:0] node id, [15:8] error_byte, [31:16] data_value
   logic [1:0]  rsp_tuser;        // [1:0] status
   logic        csr_wen = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   servo_response_packet_checker_unit #(
      .MAX_PACKET_BYTES(PKT_MAX)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Configuration as the checker should currently hold it.
   logic [4:0]  cfg_len   = srpc_pkg::RST_PACKET_LENGTH;
   logic        cfg_order = srpc_pkg::RST_BYTE_ORDER;
   logic [15:0] cfg_limit = srpc_pkg::RST_TIMEOUT_LIMIT;

   // Packet tracking state of the predictor.
   logic        trk_armed     = 1'b0;
   logic [4:0]  trk_count     = '0;
   logic [7:0]  trk_sum       = '0;
   logic        trk_header_ok = 1'b1;
   logic [7:0]  trk_id        = '0;
   logic [7:0]  trk_err       = '0;
   logic [7:0]  trk_first     = '0;
   logic [7:0]  trk_second    = '0;
   logic [15:0] trk_ticks     = '0;

   // Responses predicted but not yet seen on the response channel, oldest first.
   srpc_pkg::result_type expected_results[$];

   logic [7:0]  frame_bytes[$];

   int error_count       = 0;
   int responses_checked = 0;
   int status_seen[4]    = '{0, 0, 0, 0};
   int packet_items      = 0;
   int config_writes     = 0;
   int burst_left        = 0;
   int stall_left        = 0;
   int ready_mode        = 1;
   bit quiet_sender      = 1'b0;

   // Length the checker really uses: register values outside 6..PKT_MAX are clamped.
   function automatic logic [4:0] eff_length(input logic [4:0] n);
      if (n < srpc_pkg::MIN_PACKET) return srpc_pkg::MIN_PACKET;
      if (n > PKT_MAX) return 5'(PKT_MAX);
      return n;
   endfunction

   // Predictor: advances the packet state for one accepted request and queues the
   // response that the request closes, if any.
   function automatic void track_request(input logic [1:0] op, input logic [7:0] rx);
      srpc_pkg::result_type res;
      logic [4:0] last_pos;
      case (op)
         srpc_pkg::OP_START: begin
            // A start always clears the packet, so a start while armed restarts quietly.
            trk_armed     = 1'b1;
            trk_count     = '0;
            trk_sum       = '0;
            trk_header_ok = 1'b1;
            trk_id        = '0;
            trk_err       = '0;
            trk_first     = '0;
            trk_second    = '0;
            trk_ticks     = '0;
         end
         srpc_pkg::OP_BYTE: begin
            if (trk_armed) begin
               last_pos = eff_length(cfg_len) - 5'd1;
               if (trk_count >= last_pos) begin
                  // This byte is the checksum; a bad header outranks a bad checksum.
                  if (!trk_header_ok) res.status = srpc_pkg::ST_BAD_HEADER;
                  else if (8'(~trk_sum) != rx) res.status = srpc_pkg::ST_BAD_CHECKSUM;
                  else res.status = srpc_pkg::ST_OK;
                  res.node_id    = trk_id;
                  res.error_byte = trk_err;
                  res.data_value = cfg_order ? {trk_first, trk_second}
                                             : {trk_second, trk_first};
                  expected_results.insert(expected_results.size(), res);
                  trk_armed = 1'b0;
               end else if (trk_count < HEADER_BYTES) begin
                  if (rx != srpc_pkg::HEADER_MARK) trk_header_ok = 1'b0;
               end else begin
                  trk_sum = trk_sum + rx;
                  if (trk_count == OFS_ID) trk_id = rx;
                  else if (trk_count == OFS_ERROR) trk_err = rx;
                  else if (trk_count == OFS_VALUE_A) trk_first = rx;
                  else if (trk_count == OFS_VALUE_B) trk_second = rx;
               end
               trk_count = trk_count + 5'd1;
            end
         end
         srpc_pkg::OP_TICK: begin
            if (trk_armed) begin
               if (trk_ticks != srpc_pkg::TICK_MAX) trk_ticks = trk_ticks + 16'd1;
               if (trk_ticks >= cfg_limit) begin
                  res.status     = srpc_pkg::ST_TIMEOUT;
                  res.node_id    = '0;
                  res.error_byte = '0;
                  res.data_value = '0;
                  expected_results.insert(expected_results.size(), res);
                  trk_armed = 1'b0;
               end
            end
         end
         default: begin
            // The reserved operation is ignored.
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("MISMATCH at %0t ns: %s expected %0h got %0h", $time, what, want, got);
   endtask

   task automatic check_result();
      srpc_pkg::result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("response with nothing pending", '0, rsp_tdata);
         return;
      end
      want = expected_results.pop_front();
      responses_checked++;
      if (!$isunknown(rsp_tuser)) status_seen[rsp_tuser]++;
      if (rsp_tuser !== want.status)
         report_mismatch("status", 32'(want.status), 32'(rsp_tuser));
      if (rsp_tdata[7:0] !== want.node_id)
         report_mismatch("node id", 32'(want.node_id), 32'(rsp_tdata[7:0]));
      if (rsp_tdata[15:8] !== want.error_byte)
         report_mismatch("error_byte", 32'(want.error_byte), 32'(rsp_tdata[15:8]));
      if (rsp_tdata[31:16] !== want.data_value)
         report_mismatch("data_value", 32'(want.data_value), 32'(rsp_tdata[31:16]));
   endtask

   // Both channels are sampled at the rising edge, so every value seen here is the
   // one the checker itself saw. Responses are checked before the request of the
   // same edge is tracked.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready) track_request(req_tuser, req_tdata);
      end
   end

   // Response side: always ready, short random stalls or long random stalls,
   // depending on the mode chosen by the running test.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (ready_mode != 0 && $urandom_range(0, 3) == 0) begin
         stall_left <= $urandom_range(0, (ready_mode == 2) ? 24 : 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Presents one request and returns at the edge where it is accepted. The valid
   // stays high so that a following request goes out back to back.
   task automatic send_request(input logic [1:0] op, input logic [7:0] rx);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Sender with burst behavior: between bursts of random length the valid drops
   // for a random gap, unless the current phase runs the sender without pauses.
   task automatic push_request(input logic [1:0] op, input logic [7:0] rx);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (!quiet_sender) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      send_request(op, rx);
   endtask

   // Holds the sender until every predicted response has arrived, then lets the
   // pipeline settle. The first edge makes sure the last acceptance is tracked.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Drives one register write; the caller lowers the enable after the last one.
   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         srpc_pkg::CSR_PACKET_LENGTH: cfg_len   = data[4:0];
         srpc_pkg::CSR_BYTE_ORDER:    cfg_order = data[0];
         srpc_pkg::CSR_TIMEOUT_LIMIT: cfg_limit = data;
         default: begin
         end
      endcase
   endtask

   // Writes all three registers while the checker is idle. Unused upper data bits
   // sometimes carry junk, which the registers must drop.
   task automatic set_config(input logic [4:0] len, input logic order, input logic [15:0] lim);
      logic [15:0] junk;
      wait_drained();
      junk = $urandom_range(0, 1) ? 16'($urandom) : 16'd0;
      write_csr(srpc_pkg::CSR_PACKET_LENGTH, {junk[15:5], len});
      junk = $urandom_range(0, 1) ? 16'($urandom) : 16'd0;
      write_csr(srpc_pkg::CSR_BYTE_ORDER, {junk[15:1], order});
      write_csr(srpc_pkg::CSR_TIMEOUT_LIMIT, lim);
      csr_wen <= 1'b0;
      config_writes++;
   endtask

   // Builds an n-byte status packet into frame_bytes. fill below zero means random
   // payload bytes, otherwise every payload byte takes that value.
   function automatic void build_frame(input int n, input int hdr_fault, input bit sum_fault,
                                       input int fill);
      logic [7:0] sum;
      logic [7:0] v;
      logic [7:0] last;
      frame_bytes.delete();
      sum = '0;
      for (int i = 0; i < n - 1; i++) begin
         if (i < HEADER_BYTES) begin
            v = srpc_pkg::HEADER_MARK;
         end else begin
            v = (fill < 0) ? 8'($urandom) : fill[7:0];
            sum = sum + v;
         end
         frame_bytes.insert(frame_bytes.size(), v);
      end
      if (hdr_fault == HDR_FIRST || hdr_fault == HDR_BOTH)
         frame_bytes[0] = 8'($urandom_range(0, 254));
      if (hdr_fault == HDR_SECOND || hdr_fault == HDR_BOTH)
         frame_bytes[1] = 8'($urandom_range(0, 254));
      last = ~sum;
      if (sum_fault) last = last ^ 8'($urandom_range(1, 255));
      frame_bytes.insert(frame_bytes.size(), last);
   endfunction

   // Sends a start and the first stop_at bytes of frame_bytes, with ticks mixed in
   // at the given percentage. Non-byte requests carry random data bytes.
   task automatic send_frame(input int tick_pct, input int stop_at, output int ticks);
      ticks = 0;
      push_request(srpc_pkg::OP_START, 8'($urandom));
      packet_items++;
      for (int i = 0; i < stop_at; i++) begin
         if ($urandom_range(1, 100) <= tick_pct) begin
            push_request(srpc_pkg::OP_TICK, 8'($urandom));
            packet_items++;
            ticks++;
         end
         push_request(srpc_pkg::OP_BYTE, frame_bytes[i]);
         packet_items++;
      end
   endtask

   task automatic test_good_packets();
      int ticks;
      ready_mode = 1;
      // Reset defaults: eight bytes, little-endian, ten ticks.
      build_frame(8, HDR_NONE, 1'b0, -1);
      send_frame(0, 8, ticks);
      set_config(5'd6, 1'b0, 16'd100);
      build_frame(6, HDR_NONE, 1'b0, 0);
      send_frame(0, 6, ticks);
      // Seven bytes: only offset 5 is a value byte.
      set_config(5'd7, 1'b1, 16'd100);
      build_frame(7, HDR_NONE, 1'b0, 255);
      send_frame(0, 7, ticks);
      set_config(5'd16, 1'b1, 16'd65535);
      build_frame(16, HDR_NONE, 1'b0, 255);
      send_frame(0, 16, ticks);
      set_config(5'd16, 1'b0, 16'd65535);
      build_frame(16, HDR_NONE, 1'b0, -1);
      send_frame(0, 16, ticks);
   endtask

   task automatic test_header_checksum();
      int ticks;
      set_config(5'd8, 1'b1, 16'd200);
      build_frame(8, HDR_FIRST, 1'b0, -1);
      send_frame(0, 8, ticks);
      build_frame(8, HDR_SECOND, 1'b0, -1);
      send_frame(0, 8, ticks);
      build_frame(8, HDR_NONE, 1'b1, -1);
      send_frame(0, 8, ticks);
      // Both faults at once must still report the header.
      build_frame(8, HDR_BOTH, 1'b1, -1);
      send_frame(0, 8, ticks);
   endtask

   task automatic test_timeouts();
      int ticks;
      // Limit zero: the very first tick after start times out.
      set_config(5'd8, 1'b0, 16'd0);
      push_request(srpc_pkg::OP_START, 8'($urandom));
      push_request(srpc_pkg::OP_TICK, 8'($urandom));
      push_request(srpc_pkg::OP_TICK, 8'($urandom));
      // Timeout after a partial packet reports zero fields; later bytes are ignored.
      set_config(5'd8, 1'b1, 16'd1);
      build_frame(8, HDR_NONE, 1'b0, -1);
      send_frame(0, 5, ticks);
      push_request(srpc_pkg::OP_TICK, 8'($urandom));
      push_request(srpc_pkg::OP_BYTE, frame_bytes[5]);
      // Timeout just before the checksum byte would have closed the packet.
      set_config(5'd8, 1'b0, 16'd3);
      build_frame(8, HDR_NONE, 1'b0, -1);
      send_frame(0, 7, ticks);
      repeat (3) push_request(srpc_pkg::OP_TICK, 8'($urandom));
      push_request(srpc_pkg::OP_BYTE, frame_bytes[7]);
   endtask

   task automatic test_control_cases();
      int ticks;
      set_config(5'd16, 1'b0, 16'd1000);
      // Stray requests while idle produce nothing.
      push_request(srpc_pkg::OP_BYTE, 8'($urandom));
      push_request(srpc_pkg::OP_TICK, 8'($urandom));
      push_request(OP_RESERVED, 8'($urandom));
      // A start in the middle of a packet restarts it without a response, and the
      // reserved operation is ignored while armed too.
      build_frame(16, HDR_NONE, 1'b0, -1);
      send_frame(0, 9, ticks);
      push_request(OP_RESERVED, 8'($urandom));
      build_frame(16, HDR_NONE, 1'b0, -1);
      send_frame(0, 16, ticks);
      // Lengths outside the legal range are clamped to the nearest end.
      set_config(5'd0, 1'b1, 16'd1000);
      build_frame(6, HDR_NONE, 1'b0, -1);
      send_frame(0, 6, ticks);
      set_config(5'd31, 1'b0, 16'd1000);
      build_frame(16, HDR_NONE, 1'b0, -1);
      send_frame(0, 16, ticks);
      // A write to the unused index must leave the configuration alone.
      wait_drained();
      write_csr(CSR_UNUSED, 16'($urandom));
      csr_wen <= 1'b0;
      build_frame(16, HDR_NONE, 1'b0, -1);
      send_frame(0, 16, ticks);
      // Shortening the packet while one is open: the next byte becomes the checksum.
      set_config(5'd16, 1'b1, 16'd1000);
      build_frame(8, HDR_NONE, 1'b0, -1);
      send_frame(0, 7, ticks);
      wait_drained();
      write_csr(srpc_pkg::CSR_PACKET_LENGTH, 16'd6);
      csr_wen <= 1'b0;
      push_request(srpc_pkg::OP_BYTE, frame_bytes[7]);
   endtask

   // One random packet at the current configuration: mostly well formed, the rest
   // with faults, cut short, restarted or followed by extra requests.
   task automatic run_random_frame();
      int kind;
      int n;
      int ticks;
      int cut;
      n = int'(eff_length(cfg_len));
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
         build_frame(n, HDR_NONE, 1'b0, -1);
         send_frame(10, n, ticks);
      end else if (kind < 68) begin
         build_frame(n, $urandom_range(HDR_FIRST, HDR_BOTH), 1'b0, -1);
         send_frame(10, n, ticks);
      end else if (kind < 76) begin
         build_frame(n, HDR_NONE, 1'b1, -1);
         send_frame(10, n, ticks);
      end else if (kind < 80) begin
         build_frame(n, $urandom_range(HDR_FIRST, HDR_BOTH), 1'b1, -1);
         send_frame(10, n, ticks);
      end else if (kind < 88) begin
         // Cut short; tick it out when the limit is reachable, else leave it open.
         build_frame(n, HDR_NONE, 1'b0, -1);
         cut = $urandom_range(0, n - 1);
         send_frame(15, cut, ticks);
         if (cfg_limit <= 300) begin
            while (ticks <= int'(cfg_limit)) begin
               push_request(srpc_pkg::OP_TICK, 8'($urandom));
               packet_items++;
               ticks++;
            end
         end
      end else if (kind < 94) begin
         build_frame(n, HDR_NONE, 1'b0, -1);
         send_frame(10, $urandom_range(1, n - 1), ticks);
         build_frame(n, HDR_NONE, 1'b0, -1);
         send_frame(10, n, ticks);
      end else begin
         build_frame(n, HDR_NONE, 1'b0, -1);
         send_frame(10, n, ticks);
         repeat ($urandom_range(1, 4))
            push_request(2'($urandom_range(srpc_pkg::OP_BYTE, OP_RESERVED)), 8'($urandom));
      end
   endtask

   task automatic test_random_traffic();
      int start_items;
      int frames;
      int pause_at;
      int r;
      int len;
      int lim;
      start_items = packet_items;
      while (packet_items - start_items < RANDOM_ITEMS) begin
         r = $urandom_range(0, 9);
         if (r == 0) len = $urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom_range(17, 31);
         else if (r == 1) len = 6;
         else if (r == 2) len = 16;
         else len = $urandom_range(6, 16);
         r = $urandom_range(0, 19);
         if (r < 3) lim = $urandom_range(0, 3);
         else if (r < 7) lim = $urandom_range(4, 29);
         else if (r < 9) lim = 65535;
         else if (r < 11) lim = $urandom_range(0, 65535);
         else lim = $urandom_range(30, 200);
         set_config(len[4:0], 1'($urandom_range(0, 1)), lim[15:0]);
         ready_mode   = $urandom_range(0, 2);
         quiet_sender = ($urandom_range(0, 3) == 0);
         frames   = $urandom_range(4, 16);
         pause_at = $urandom_range(0, frames - 1);
         for (int i = 0; i < frames; i++) begin
            // Somewhere in each phase the sender waits for all responses.
            if (i == pause_at) wait_drained();
            run_random_frame();
            if ($urandom_range(0, 9) == 0) push_request(2'($urandom_range(0, 3)), 8'($urandom));
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_good_packets();
      test_header_checksum();
      test_timeouts();
      test_control_cases();
      test_random_traffic();
      wait_drained();
      $display("Covered %0d packet requests, %0d configuration settings, %0d responses checked.",
               packet_items, config_writes, responses_checked);
      $display("Responses by status: ok %0d, timeout %0d, bad header %0d, bad checksum %0d.",
               status_seen[srpc_pkg::ST_OK], status_seen[srpc_pkg::ST_TIMEOUT],
               status_seen[srpc_pkg::ST_BAD_HEADER], status_seen[srpc_pkg::ST_BAD_CHECKSUM]);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #(WATCHDOG_NS);
      $display("Run limit reached with %0d responses still pending.", expected_results.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
